FILE: sv/assert_macros.svh
// assertion macros used by the checker file
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

FILE: sv/shk_pkg.sv
// package for the held key tracker: sizes, codes, state types, lookup functions
// no dependencies
package shk_pkg;

  localparam int MAX_KEYS = 16;
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int BYTE_W   = 8;
  localparam int KEY_W    = 7;
  localparam int TONE_W   = 10;
  localparam int LIMIT_W  = 5;
  localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam logic [BYTE_W-1:0]  BREAK_CODE  = 8'hF0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
  localparam logic [KEY_W-1:0]   NO_KEY      = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } shk_state_t;

  typedef enum logic {
    OP_PRESS,
    OP_RELEASE
  } shk_op_t;

  // control from the sequencer to the key list
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
    logic [KEY_W-1:0] key;
  } shk_list_ctl_t;

  // set-2 make code to ascii, zero for unsupported codes
  function automatic logic [KEY_W-1:0] scan_to_ascii(input logic [BYTE_W-1:0] code);
    logic [KEY_W-1:0] k;
    unique case (code)
      8'h1C:   k = 7'h61;
      8'h32:   k = 7'h62;
      8'h21:   k = 7'h63;
      8'h23:   k = 7'h64;
      8'h24:   k = 7'h65;
      8'h2B:   k = 7'h66;
      8'h34:   k = 7'h67;
      8'h45:   k = 7'h30;
      8'h16:   k = 7'h31;
      8'h1E:   k = 7'h32;
      8'h26:   k = 7'h33;
      8'h25:   k = 7'h34;
      8'h2E:   k = 7'h35;
      8'h36:   k = 7'h36;
      8'h3D:   k = 7'h37;
      8'h3E:   k = 7'h38;
      8'h46:   k = 7'h39;
      default: k = NO_KEY;
    endcase
    return k;
  endfunction

  // tone in hz for a held key
  function automatic logic [TONE_W-1:0] ascii_to_tone(input logic [KEY_W-1:0] k);
    logic [TONE_W-1:0] t;
    unique case (k)
      7'h61:   t = 10'd440;
      7'h62:   t = 10'd494;
      7'h63:   t = 10'd262;
      7'h64:   t = 10'd294;
      7'h65:   t = 10'd330;
      7'h66:   t = 10'd349;
      7'h67:   t = 10'd392;
      7'h31:   t = 10'd100;
      7'h32:   t = 10'd200;
      7'h33:   t = 10'd300;
      7'h34:   t = 10'd400;
      7'h35:   t = 10'd500;
      7'h36:   t = 10'd600;
      7'h37:   t = 10'd700;
      7'h38:   t = 10'd800;
      7'h39:   t = 10'd900;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

FILE: sv/shk_in_if.sv
// item channel interfaces: scan byte in, held key result out
// depends on shk_pkg for field widths
interface shk_in_if;
  logic                      valid;
  logic                      ready;
  logic [shk_pkg::BYTE_W-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface shk_out_if;
  logic                       valid;
  logic                       ready;
  logic [shk_pkg::KEY_W-1:0]  last_key;
  logic [shk_pkg::TONE_W-1:0] tone_hz;
  logic [shk_pkg::CNT_W-1:0]  held_count;

  modport source (output valid, output last_key, output tone_hz, output held_count,
                  input ready);
  modport sink   (input valid, input last_key, input tone_hz, input held_count,
                  output ready);
endinterface

FILE: sv/shk_keylist.sv
// held key storage with one write port, one read port and the shared key compare
// depends on shk_pkg
module shk_keylist (
  input  logic                   clk,
  input  shk_pkg::shk_list_ctl_t ctl,
  output logic [shk_pkg::KEY_W-1:0] rd_key,
  output logic                   match
);
  import shk_pkg::*;

  logic [KEY_W-1:0] keys_r [MAX_KEYS];

  // single write port; entries past the count may be read, but their data is never used
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      keys_r[ctl.waddr] <= ctl.wdata;
    end
  end

  // read port and the compare unit used by the list walk
  assign rd_key = keys_r[ctl.raddr];
  assign match  = (rd_key == ctl.key);

endmodule

FILE: sv/shk_ctrl.sv
// sequencer: decodes the scan byte, walks the list for lookup and shift-down
// depends on shk_pkg
module shk_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [shk_pkg::BYTE_W-1:0]  scan_byte,
  output logic                        in_ready,
  input  logic [shk_pkg::LIMIT_W-1:0] list_limit,
  input  logic [shk_pkg::KEY_W-1:0]   rd_key,
  input  logic                        match,
  input  logic                        out_free,
  output shk_pkg::shk_list_ctl_t      ctl,
  output logic                        fin_valid,
  output logic [shk_pkg::CNT_W-1:0]   count
);
  import shk_pkg::*;

  shk_state_t       state_r, state_nxt;
  shk_op_t          op_r, op_nxt;
  logic             bp_r, bp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  logic [KEY_W-1:0] in_key;
  logic [CNT_W-1:0] ptr_inc;
  logic [CMP_W-1:0] lim_ext, cnt_ext, eff_limit;
  logic             room;

  assign in_key  = scan_to_ascii(scan_byte);
  assign ptr_inc = ptr_r + 1'b1;

  // effective slot limit, capped at the list depth
  always_comb begin
    lim_ext   = CMP_W'(list_limit);
    cnt_ext   = CMP_W'(count_r);
    eff_limit = (lim_ext > CMP_W'(MAX_KEYS)) ? CMP_W'(MAX_KEYS) : lim_ext;
    room      = (cnt_ext < eff_limit);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          priority if (bp_r) begin
            state_nxt = (in_key != NO_KEY) ? ST_SCAN : ST_FINISH;
          end else if (scan_byte == BREAK_CODE) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = (in_key != NO_KEY) ? ST_SCAN : ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        priority if (ptr_r == count_r) begin
          state_nxt = ST_FINISH;
        end else if (match) begin
          state_nxt = (op_r == OP_RELEASE) ? ST_SHIFT : ST_FINISH;
        end
      end
      ST_SHIFT: begin
        if (ptr_inc >= count_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and register updates per state
  always_comb begin
    op_nxt    = op_r;
    bp_nxt    = bp_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    ctl.we    = 1'b0;
    ctl.waddr = ptr_r[IDX_W-1:0];
    ctl.wdata = rd_key;
    ctl.raddr = IDX_W'(count_r - 1'b1);
    ctl.key   = key_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ptr_nxt = '0;
          key_nxt = in_key;
          priority if (bp_r) begin
            bp_nxt = 1'b0;
            op_nxt = OP_RELEASE;
          end else if (scan_byte == BREAK_CODE) begin
            bp_nxt = 1'b1;
          end else begin
            op_nxt = OP_PRESS;
          end
        end
      end
      ST_SCAN: begin
        ctl.raddr = ptr_r[IDX_W-1:0];
        priority if (ptr_r == count_r) begin
          // key absent: append on press if there is room
          if (op_r == OP_PRESS && room) begin
            ctl.we    = 1'b1;
            ctl.waddr = count_r[IDX_W-1:0];
            ctl.wdata = key_r;
            count_nxt = count_r + 1'b1;
          end
        end else if (!match) begin
          ptr_nxt = ptr_inc;
        end
      end
      ST_SHIFT: begin
        // move the next entry down one place, then drop the tail
        ctl.raddr = ptr_inc[IDX_W-1:0];
        if (ptr_inc < count_r) begin
          ctl.we  = 1'b1;
          ptr_nxt = ptr_inc;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bp_r    <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      bp_r    <= bp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign fin_valid = (state_r == ST_FINISH);
  assign count     = count_r;

endmodule

FILE: sv/scan_code_held_key_tracker.sv
// top level of the held key tracker: config register, result register, wiring
// depends on shk_pkg, shk_in_if, shk_out_if, shk_keylist, shk_ctrl
//
// Usage:
//   in_item  carries one PS/2 set-2 scan byte per item (valid/ready).
//   out_item returns exactly one result per input item: the most recently
//            pressed key still held (ascii, 0 if none), its tone in hz and
//            the number of held keys.
//   cfg_we / cfg_wdata write list_limit (reset 16, values above 16 act as 16);
//            write only while the block is idle.
// Sequence:
//   the accepting edge decodes the item, then the list entries are looked up
//   one at a time through the single read port and compare unit, entries are
//   moved down one place on a release and the tail is dropped, and a finish
//   state loads the result register.
//   in_ready is high only while the sequencer is idle, so one item is in
//   work at a time; the next item can be accepted while a result waits.
// Reset:
//   synchronous, active low; clears the held list, the break flag and the
//   result valid, and sets list_limit to 16.
// Stall:
//   a result not taken holds in the output register; a finished item waits
//   for it to drain before going idle again.
module scan_code_held_key_tracker (
  input  logic                        clk,
  input  logic                        rst_n,
  shk_in_if.sink                      in_item,
  shk_out_if.source                   out_item,
  input  logic                        cfg_we,
  input  logic [shk_pkg::LIMIT_W-1:0] cfg_wdata
);
  import shk_pkg::*;

  logic [LIMIT_W-1:0] list_limit_r;
  shk_list_ctl_t      ctl;
  logic [KEY_W-1:0]   rd_key;
  logic               match;
  logic               fin_valid;
  logic [CNT_W-1:0]   count;
  logic               out_free;

  logic               out_valid_r;
  logic [KEY_W-1:0]   last_key_r, last_key_nxt;
  logic [TONE_W-1:0]  tone_r;
  logic [CNT_W-1:0]   held_count_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      list_limit_r <= cfg_wdata;
    end
  end

  shk_keylist u_list (
    .clk    (clk),
    .ctl    (ctl),
    .rd_key (rd_key),
    .match  (match)
  );

  shk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .scan_byte  (in_item.scan_byte),
    .in_ready   (in_item.ready),
    .list_limit (list_limit_r),
    .rd_key     (rd_key),
    .match      (match),
    .out_free   (out_free),
    .ctl        (ctl),
    .fin_valid  (fin_valid),
    .count      (count)
  );

  // result register, loaded when the finished item finds it free
  assign out_free     = !out_valid_r || out_item.ready;
  assign last_key_nxt = (count == '0) ? NO_KEY : rd_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_free) begin
      last_key_r   <= last_key_nxt;
      tone_r       <= ascii_to_tone(last_key_nxt);
      held_count_r <= count;
    end
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.last_key   = last_key_r;
  assign out_item.tone_hz    = tone_r;
  assign out_item.held_count = held_count_r;

endmodule

FILE: sv/shk_checker.sv
// port-level checker for the held key tracker, bound to the top level
// depends on shk_pkg and assert_macros.svh
`include "assert_macros.svh"

module shk_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [shk_pkg::KEY_W-1:0]  last_key,
  input logic [shk_pkg::TONE_W-1:0] tone_hz,
  input logic [shk_pkg::CNT_W-1:0]  held_count
);
  import shk_pkg::*;

  // stalled result holds its payload
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(last_key) && $stable(held_count))

  // one item at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // count never exceeds the list depth
  `ASSERT_SAME(a_count_range, out_valid, held_count <= CNT_W'(MAX_KEYS))

  // empty list reports no key and no tone, non-empty list a key
  `ASSERT_SAME(a_empty_zero, out_valid && held_count == '0, last_key == '0 && tone_hz == '0)
  `ASSERT_SAME(a_held_key, out_valid && held_count != '0, last_key != '0)

endmodule

bind scan_code_held_key_tracker shk_checker u_shk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_item.valid),
  .in_ready   (in_item.ready),
  .out_valid  (out_item.valid),
  .out_ready  (out_item.ready),
  .last_key   (out_item.last_key),
  .tone_hz    (out_item.tone_hz),
  .held_count (out_item.held_count)
);
